// ===== rtl/xcfrle_pkg.sv =====
package xcfrle_pkg;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 7;
    localparam int SIDE_W      = 7;
    localparam int PLANES_W    = 3;
    localparam int PIX_W       = 14;
    localparam int RUN_W       = 16;

    localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 2'd2;

    localparam logic [SIDE_W-1:0]   TILE_SIDE_RST = 7'd64;
    localparam logic [PLANES_W-1:0] BPP_RST       = 3'd4;

    localparam logic [8:0] LONG_LEN = 9'd128;
    localparam logic [8:0] LIT_BIAS = 9'd256;

    typedef struct packed {
        logic [PIX_W-1:0]    plane_size;
        logic [PLANES_W-1:0] planes;
    } geom_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data_byte;
        logic       tile_start;
    } stage_t;

endpackage

// ===== rtl/xcfrle_if.sv =====
interface xcfrle_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       tile_start;

    modport source (output valid, output data_byte, output tile_start, input ready);
    modport sink (input valid, input data_byte, input tile_start, output ready);
endinterface

interface xcfrle_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  channel;
    logic [11:0] start_pixel;
    logic [7:0]  value;
    logic [12:0] run_length;
    logic        overrun;
    logic        last;

    modport source (output valid, output channel, output start_pixel, output value,
                    output run_length, output overrun, output last, input ready);
    modport sink (input valid, input channel, input start_pixel, input value,
                  input run_length, input overrun, input last, output ready);
endinterface

interface xcfrle_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [6:0] wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

// ===== rtl/xcfrle_cfg.sv =====
module xcfrle_cfg #(
    parameter int MAX_TILE_SIDE = 64,
    parameter int MAX_CHANNELS  = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    xcfrle_cfg_if.sink         cfg,
    output xcfrle_pkg::geom_t  geom
);
    import xcfrle_pkg::*;

    localparam int SIDE_CAP = (MAX_TILE_SIDE > 127) ? 127 : MAX_TILE_SIDE;
    localparam int CH_CAP   = (MAX_CHANNELS > 7) ? 7 : MAX_CHANNELS;
    localparam int SIDE_RST = (SIDE_CAP < 64) ? SIDE_CAP : 64;
    localparam int CH_RST   = (CH_CAP < 4) ? CH_CAP : 4;
    localparam logic [SIDE_W-1:0]   SIDE_HI = SIDE_CAP[SIDE_W-1:0];
    localparam logic [PLANES_W-1:0] CH_HI   = CH_CAP[PLANES_W-1:0];
    localparam logic [PIX_W-1:0]    PS_RST  = PIX_W'(SIDE_RST * SIDE_RST);
    localparam logic [PLANES_W-1:0] PL_RST  = CH_RST[PLANES_W-1:0];

    logic [SIDE_W-1:0]   width_reg;
    logic [SIDE_W-1:0]   height_reg;
    logic [PLANES_W-1:0] bpp_reg;
    logic [SIDE_W-1:0]   width_eff;
    logic [SIDE_W-1:0]   height_eff;
    logic [PLANES_W-1:0] bpp_eff;
    geom_t               geom_reg;
    geom_t               geom_next;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        width_eff  = (width_reg == '0) ? SIDE_W'(1) : (width_reg > SIDE_HI) ? SIDE_HI : width_reg;
        height_eff = (height_reg == '0) ? SIDE_W'(1) :
                     (height_reg > SIDE_HI) ? SIDE_HI : height_reg;
        bpp_eff    = (bpp_reg == '0) ? PLANES_W'(1) : (bpp_reg > CH_HI) ? CH_HI : bpp_reg;
        geom_next.plane_size = PIX_W'(width_eff) * PIX_W'(height_eff);
        geom_next.planes     = bpp_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg           <= TILE_SIDE_RST;
            height_reg          <= TILE_SIDE_RST;
            bpp_reg             <= BPP_RST;
            geom_reg.plane_size <= PS_RST;
            geom_reg.planes     <= PL_RST;
        end
        else
        begin
            geom_reg <= geom_next;
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    REG_TILE_WIDTH:      width_reg  <= cfg.wdata;
                    REG_TILE_HEIGHT:     height_reg <= cfg.wdata;
                    REG_BYTES_PER_PIXEL: bpp_reg    <= cfg.wdata[PLANES_W-1:0];
                    default:             ;
                endcase
            end
        end
    end

    assign geom = geom_reg;

endmodule

// ===== rtl/xcfrle_in_stage.sv =====
module xcfrle_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    xcfrle_in_if.sink           din,
    input  logic                advance,
    output xcfrle_pkg::stage_t  stage
);
    import xcfrle_pkg::*;

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       start_reg;

    assign din.ready = !valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (din.ready)
        begin
            valid_reg <= din.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (din.valid && din.ready)
        begin
            byte_reg  <= din.data_byte;
            start_reg <= din.tile_start;
        end
    end

    assign stage.valid      = valid_reg;
    assign stage.data_byte  = byte_reg;
    assign stage.tile_start = start_reg;

endmodule

// ===== rtl/xcfrle_decode.sv =====
module xcfrle_decode (
    input  logic                clk,
    input  logic                rst_n,
    input  xcfrle_pkg::stage_t  stage,
    input  xcfrle_pkg::geom_t   geom,
    output logic                advance,
    xcfrle_out_if.source        dout
);
    import xcfrle_pkg::*;

    typedef enum logic [2:0] {
        PH_OPCODE,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_LITERAL,
        PH_VALUE
    } phase_t;

    phase_t              phase_reg, phase_next, cur_phase;
    logic [PLANES_W-1:0] plane_reg, plane_next, cur_plane;
    logic [PIX_W-1:0]    pos_reg, pos_next, cur_pos;
    logic [RUN_W-1:0]    rr_reg, rr_next, cur_rr;
    logic                lit_reg, lit_next, cur_lit;
    logic [7:0]          hi_reg, hi_next, cur_hi;
    logic                done_reg, done_next, cur_done;

    logic                out_valid_reg;
    logic [1:0]          channel_reg;
    logic [11:0]         start_reg;
    logic [7:0]          value_reg;
    logic [12:0]         len_reg;
    logic                over_reg;
    logic                last_reg;

    logic [7:0]          b;
    logic [8:0]          op_len;
    logic [RUN_W-1:0]    long_len;
    logic [PIX_W-1:0]    left;
    logic                final_plane;
    logic                fin_req;
    logic [PIX_W-1:0]    pos_after;
    logic                emit_v;
    logic [PIX_W-1:0]    e_len;
    logic                e_over;
    logic                e_last;

    assign advance = stage.valid && (!out_valid_reg || dout.ready);

    always_comb
    begin
        b         = stage.data_byte;
        cur_phase = stage.tile_start ? PH_OPCODE : phase_reg;
        cur_plane = stage.tile_start ? '0 : plane_reg;
        cur_pos   = stage.tile_start ? '0 : pos_reg;
        cur_rr    = stage.tile_start ? '0 : rr_reg;
        cur_lit   = stage.tile_start ? 1'b0 : lit_reg;
        cur_hi    = stage.tile_start ? '0 : hi_reg;
        cur_done  = stage.tile_start ? 1'b0 : done_reg;

        phase_next = cur_phase;
        plane_next = cur_plane;
        rr_next    = cur_rr;
        lit_next   = cur_lit;
        hi_next    = cur_hi;
        done_next  = cur_done;

        left        = (cur_pos >= geom.plane_size) ? '0 : geom.plane_size - cur_pos;
        final_plane = ({1'b0, cur_plane} + 4'd1) >= {1'b0, geom.planes};
        op_len      = b[7] ? (LIT_BIAS - {1'b0, b}) : ({1'b0, b} + 9'd1);
        long_len    = {cur_hi, b};
        fin_req     = 1'b0;
        pos_after   = cur_pos;
        emit_v      = 1'b0;
        e_len       = '0;
        e_over      = 1'b0;

        if (!cur_done)
        begin
            unique case (cur_phase)
                PH_OPCODE:
                begin
                    lit_next = b[7];
                    if (op_len == LONG_LEN)
                    begin
                        phase_next = PH_LEN_HI;
                    end
                    else
                    begin
                        rr_next    = RUN_W'(op_len);
                        phase_next = b[7] ? PH_LITERAL : PH_VALUE;
                    end
                end
                PH_LEN_HI:
                begin
                    hi_next    = b;
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    rr_next = long_len;
                    if (!cur_lit)
                        phase_next = PH_VALUE;
                    else if (long_len == '0)
                        fin_req = 1'b1;
                    else
                        phase_next = PH_LITERAL;
                end
                PH_LITERAL:
                begin
                    if (left != '0)
                    begin
                        emit_v    = 1'b1;
                        e_len     = PIX_W'(1);
                        e_over    = cur_rr > {2'b00, left};
                        pos_after = cur_pos + PIX_W'(1);
                    end
                    rr_next = cur_rr - RUN_W'(1);
                    fin_req = (rr_next == '0);
                end
                PH_VALUE:
                begin
                    if (cur_rr != '0 && left != '0)
                    begin
                        emit_v    = 1'b1;
                        e_over    = cur_rr > {2'b00, left};
                        e_len     = e_over ? left : cur_rr[PIX_W-1:0];
                        pos_after = cur_pos + e_len;
                    end
                    rr_next = '0;
                    fin_req = 1'b1;
                end
                default:
                begin
                    phase_next = PH_OPCODE;
                end
            endcase
        end

        pos_next = pos_after;
        if (fin_req)
        begin
            phase_next = PH_OPCODE;
            if (pos_after >= geom.plane_size)
            begin
                if (final_plane)
                begin
                    done_next = 1'b1;
                end
                else
                begin
                    plane_next = cur_plane + PLANES_W'(1);
                    pos_next   = '0;
                end
            end
        end

        e_last = final_plane &&
                 (({1'b0, cur_pos} + {1'b0, e_len}) >= {1'b0, geom.plane_size});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_OPCODE;
            plane_reg     <= '0;
            pos_reg       <= '0;
            rr_reg        <= '0;
            lit_reg       <= 1'b0;
            hi_reg        <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg     <= phase_next;
            plane_reg     <= plane_next;
            pos_reg       <= pos_next;
            rr_reg        <= rr_next;
            lit_reg       <= lit_next;
            hi_reg        <= hi_next;
            done_reg      <= done_next;
            out_valid_reg <= emit_v;
        end
        else if (dout.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit_v)
        begin
            channel_reg <= cur_plane[1:0];
            start_reg   <= cur_pos[11:0];
            value_reg   <= b;
            len_reg     <= e_len[12:0];
            over_reg    <= e_over;
            last_reg    <= e_last;
        end
    end

    assign dout.valid       = out_valid_reg;
    assign dout.channel     = channel_reg;
    assign dout.start_pixel = start_reg;
    assign dout.value       = value_reg;
    assign dout.run_length  = len_reg;
    assign dout.overrun     = over_reg;
    assign dout.last        = last_reg;

endmodule

// ===== rtl/xcf_rle_tile_decoder_core.sv =====
// Run-length tile decoder: takes one compressed byte per cycle on din and
// returns at most one run per byte on dout (channel, start pixel, value,
// length, overrun, last). Each byte passes an input register and one
// decode step into the result register, which presents the result on
// dout; a new byte can be taken every cycle while dout keeps up, and only
// a stalled dout holds din back. Geometry written on cfg passes the setting
// registers and then the geometry register before it applies to decoding.
module xcf_rle_tile_decoder_core #(
    parameter int MAX_TILE_SIDE = 64,
    parameter int MAX_CHANNELS  = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    xcfrle_cfg_if.sink    cfg,
    xcfrle_in_if.sink     din,
    xcfrle_out_if.source  dout
);
    import xcfrle_pkg::*;

    geom_t  geom;
    stage_t stage;
    logic   advance;

    xcfrle_cfg #(
        .MAX_TILE_SIDE (MAX_TILE_SIDE),
        .MAX_CHANNELS  (MAX_CHANNELS)
    ) u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .geom  (geom)
    );

    xcfrle_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .din     (din),
        .advance (advance),
        .stage   (stage)
    );

    xcfrle_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .stage   (stage),
        .geom    (geom),
        .advance (advance),
        .dout    (dout)
    );

endmodule

// ===== rtl/xcfrle_checker.sv =====
module xcfrle_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        din_valid,
    input logic        din_ready,
    input logic        dout_valid,
    input logic        dout_ready,
    input logic [1:0]  dout_channel,
    input logic [11:0] dout_start_pixel,
    input logic [7:0]  dout_value,
    input logic [12:0] dout_run_length,
    input logic        dout_overrun,
    input logic        dout_last
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        dout_valid && !dout_ready |=> dout_valid)
        else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        dout_valid && !dout_ready |=>
            $stable(dout_channel) && $stable(dout_start_pixel) && $stable(dout_value)
            && $stable(dout_run_length) && $stable(dout_overrun) && $stable(dout_last))
        else $error("result payload changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        dout_valid |-> dout_run_length != 13'd0)
        else $error("zero-length run emitted");

    // a fresh result needs a byte transfer that has passed the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(dout_valid) |-> $past(din_valid && din_ready, 2))
        else $error("result without input transfer");

endmodule

bind xcf_rle_tile_decoder_core xcfrle_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .din_valid        (din.valid),
    .din_ready        (din.ready),
    .dout_valid       (dout.valid),
    .dout_ready       (dout.ready),
    .dout_channel     (dout.channel),
    .dout_start_pixel (dout.start_pixel),
    .dout_value       (dout.value),
    .dout_run_length  (dout.run_length),
    .dout_overrun     (dout.overrun),
    .dout_last        (dout.last)
);
